// ===== design/dotp_pkg.sv =====
// Package for the DHCP options parser: item and result types, parse phases,
// status codes, and the option-code lookup functions.
// No dependencies; every other file but dotp_chan_if imports it.
package dotp_pkg;

    // Widths fixed by the field definitions.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FLAGS_W  = 4;
    localparam int unsigned COUNT_W  = 3;

    // Number of value bytes gathered into one captured word.
    localparam logic [COUNT_W-1:0] VALUE_BYTES = 3'd4;
    localparam logic [COUNT_W-1:0] LAST_COOKIE_IDX = 3'd3;

    // Special option codes.
    localparam logic [BYTE_W-1:0] OPT_PAD    = 8'd0;
    localparam logic [BYTE_W-1:0] OPT_MASK   = 8'd1;
    localparam logic [BYTE_W-1:0] OPT_ROUTER = 8'd3;
    localparam logic [BYTE_W-1:0] OPT_DNS    = 8'd6;
    localparam logic [BYTE_W-1:0] OPT_LEASE  = 8'd51;
    localparam logic [BYTE_W-1:0] OPT_END    = 8'd255;

    // Bits of the found mask.
    localparam logic [FLAGS_W-1:0] FLAG_NONE   = 4'b0000;
    localparam logic [FLAGS_W-1:0] FLAG_MASK   = 4'b0001;
    localparam logic [FLAGS_W-1:0] FLAG_ROUTER = 4'b0010;
    localparam logic [FLAGS_W-1:0] FLAG_DNS    = 4'b0100;
    localparam logic [FLAGS_W-1:0] FLAG_LEASE  = 4'b1000;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BADCOOKIE = 2'd1,
        ST_TRUNC     = 2'd2
    } t_status;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_COOKIE = 5'b00001,
        PH_CODE   = 5'b00010,
        PH_LEN    = 5'b00100,
        PH_VALUE  = 5'b01000,
        PH_DRAIN  = 5'b10000
    } t_phase;

    // One input item.
    typedef struct packed {
        logic [BYTE_W-1:0] option_byte;
        logic              frame_last;
        logic [WORD_W-1:0] client_address;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0] parse_status;
        logic [WORD_W-1:0]   assigned_address;
        logic [WORD_W-1:0]   netmask;
        logic [WORD_W-1:0]   gateway;
        logic [WORD_W-1:0]   name_server;
        logic [WORD_W-1:0]   lease_seconds;
        logic [FLAGS_W-1:0]  found_mask;
    } t_result;

    // Expected magic cookie byte at a given position.
    function automatic logic [BYTE_W-1:0] cookie_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = 8'h63;
            2'd1:    b = 8'h82;
            2'd2:    b = 8'h53;
            default: b = 8'h63;
        endcase
        return b;
    endfunction

    // Found-mask bit for an option whose value is captured, none otherwise.
    function automatic logic [FLAGS_W-1:0] flag_of_code(input logic [BYTE_W-1:0] code);
        logic [FLAGS_W-1:0] f;
        case (code)
            OPT_MASK:   f = FLAG_MASK;
            OPT_ROUTER: f = FLAG_ROUTER;
            OPT_DNS:    f = FLAG_DNS;
            OPT_LEASE:  f = FLAG_LEASE;
            default:    f = FLAG_NONE;
        endcase
        return f;
    endfunction

endpackage

// ===== design/dotp_chan_if.sv =====
// Valid/ready channel interface used for both the input and result streams.
// The payload type is a parameter; the block uses the types of dotp_pkg.
interface dotp_chan_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/dotp_parse_core.sv =====
// Parser core: input register, parse state, and the single-pass next-state
// and result logic. Depends on dotp_pkg.
module dotp_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input item side
    input  logic              i_in_valid,
    input  dotp_pkg::t_in_item i_in_item,
    output logic              o_in_ready,
    // Result side toward the output register
    output logic              o_res_valid,
    output dotp_pkg::t_result o_res_item,
    input  logic              i_res_ready
);
    import dotp_pkg::*;

    // Input register stage.
    logic     r_in_valid;
    t_in_item r_in;

    // Parse state.
    t_phase              r_phase,  n_phase;
    logic [COUNT_W-1:0]  r_count,  n_count;
    logic [BYTE_W-1:0]   r_code,   n_code;
    logic [BYTE_W-1:0]   r_remain, n_remain;
    logic [23:0]         r_shift,  n_shift;
    logic [WORD_W-1:0]   r_mask,   n_mask;
    logic [WORD_W-1:0]   r_gw,     n_gw;
    logic [WORD_W-1:0]   r_dns,    n_dns;
    logic [WORD_W-1:0]   r_lease,  n_lease;
    logic [WORD_W-1:0]   r_client, n_client;
    logic [FLAGS_W-1:0]  r_seen,   n_seen;

    logic               emit;
    t_status            status;
    logic [FLAGS_W-1:0] flag;
    logic [WORD_W-1:0]  value;
    logic               advance;

    // The registered item moves on unless its result cannot be handed over.
    assign advance    = !(emit && !i_res_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Next-state and result logic for the item held in the input register.
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_code   = r_code;
        n_remain = r_remain;
        n_shift  = r_shift;
        n_mask   = r_mask;
        n_gw     = r_gw;
        n_dns    = r_dns;
        n_lease  = r_lease;
        n_client = r_client;
        n_seen   = r_seen;
        emit     = 1'b0;
        status   = ST_OK;
        flag     = flag_of_code(r_code);
        value    = {r_shift, r_in.option_byte};

        case (r_phase)
            PH_COOKIE: begin
                // First byte of a frame samples the client and clears captures.
                if (r_count == '0) begin
                    n_client = r_in.client_address;
                    n_mask   = '0;
                    n_gw     = '0;
                    n_dns    = '0;
                    n_lease  = '0;
                    n_seen   = '0;
                end
                if (r_in.option_byte != cookie_byte(r_count[1:0])) begin
                    emit   = 1'b1;
                    status = ST_BADCOOKIE;
                end else if (r_count == LAST_COOKIE_IDX) begin
                    n_count = '0;
                    n_phase = PH_CODE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            PH_CODE: begin
                if (r_in.option_byte == OPT_END) begin
                    emit   = 1'b1;
                    status = ST_OK;
                end else if (r_in.option_byte != OPT_PAD) begin
                    n_code  = r_in.option_byte;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_remain = r_in.option_byte;
                n_count  = '0;
                n_shift  = '0;
                n_phase  = (r_in.option_byte != '0) ? PH_VALUE : PH_CODE;
            end
            PH_VALUE: begin
                // Gather the first four value bytes of a captured option.
                if (flag != FLAG_NONE && r_count < VALUE_BYTES) begin
                    n_shift = value[23:0];
                    n_count = r_count + 1'b1;
                    if (r_count == VALUE_BYTES - 1'b1) begin
                        if (flag == FLAG_MASK)   n_mask  = value;
                        if (flag == FLAG_ROUTER) n_gw    = value;
                        if (flag == FLAG_DNS)    n_dns   = value;
                        if (flag == FLAG_LEASE)  n_lease = value;
                        n_seen = r_seen | flag;
                    end
                end
                n_remain = r_remain - 1'b1;
                if (r_remain == 8'd1) begin
                    n_phase = PH_CODE;
                end
            end
            default: begin
                // Draining until the end of the frame.
            end
        endcase

        // Frame ended before any result was given.
        if (r_in.frame_last && !emit && r_phase != PH_DRAIN) begin
            emit   = 1'b1;
            status = ST_TRUNC;
        end
        if (emit) begin
            n_phase = PH_DRAIN;
        end
        // Every frame end prepares for the next cookie.
        if (r_in.frame_last) begin
            n_phase  = PH_COOKIE;
            n_count  = '0;
            n_remain = '0;
            n_shift  = '0;
            n_code   = '0;
        end

        emit = emit && r_in_valid;
    end

    // Result carries the capture values as updated by this item.
    assign o_res_valid = emit;
    always_comb begin
        o_res_item.parse_status     = status;
        o_res_item.assigned_address = n_client;
        o_res_item.netmask          = n_mask;
        o_res_item.gateway          = n_gw;
        o_res_item.name_server      = n_dns;
        o_res_item.lease_seconds    = n_lease;
        o_res_item.found_mask       = n_seen;
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Parse state advances once per consumed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COOKIE;
            r_count  <= '0;
            r_code   <= '0;
            r_remain <= '0;
            r_shift  <= '0;
            r_mask   <= '0;
            r_gw     <= '0;
            r_dns    <= '0;
            r_lease  <= '0;
            r_client <= '0;
            r_seen   <= '0;
        end else if (r_in_valid && advance) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_code   <= n_code;
            r_remain <= n_remain;
            r_shift  <= n_shift;
            r_mask   <= n_mask;
            r_gw     <= n_gw;
            r_dns    <= n_dns;
            r_lease  <= n_lease;
            r_client <= n_client;
            r_seen   <= n_seen;
        end
    end

endmodule

// ===== design/dotp_out_reg.sv =====
// Result register between the parser core and the result channel.
// Depends on dotp_pkg.
module dotp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dotp_pkg::t_result i_item,
    output logic              o_ready,
    output logic              o_valid,
    output dotp_pkg::t_result o_item,
    input  logic              i_ready
);
    import dotp_pkg::*;

    logic    r_valid;
    t_result r_item;

    // Takes a new item when empty or when the held one leaves this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== design/dhcp_option_tlv_parser_top.sv =====
// Top level of the DHCP options parser: input channel, parser core and
// result register. Depends on dotp_pkg, dotp_chan_if, dotp_parse_core, dotp_out_reg.
//
// Usage:
// i_item carries the options area one byte per item, cookie first, with
// frame_last on the final byte and the offered client address (sampled on
// the first byte of each frame). o_result carries at most one item per
// frame: ok on the end option, bad cookie on the first mismatching cookie
// byte, or truncated when the frame ends without either. Bytes after a
// result are dropped up to frame_last.
// Throughput is one byte per clock while no result waits on a stalled
// receiver. An accepted byte is held in the input register; its result is
// computed combinationally from it and registered in the output register,
// from which the receiver takes it.
// Synchronous active-low reset empties both registers and returns the
// parser to the cookie phase of a new frame. When the receiver stalls,
// bytes that give no result keep flowing; a byte that gives a result waits
// in the input register, and only then does i_item.ready drop.
module dhcp_option_tlv_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dotp_chan_if.sink    i_item,
    dotp_chan_if.source  o_result
);
    import dotp_pkg::*;

    logic    core_valid;
    logic    core_ready;
    t_result core_item;

    // Byte walker and capture state.
    dotp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_item   (i_item.payload),
        .o_in_ready  (i_item.ready),
        .o_res_valid (core_valid),
        .o_res_item  (core_item),
        .i_res_ready (core_ready)
    );

    // Result register toward the receiver.
    dotp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (core_valid),
        .i_item  (core_item),
        .o_ready (core_ready),
        .o_valid (o_result.valid),
        .o_item  (o_result.payload),
        .i_ready (o_result.ready)
    );

endmodule

// ===== verif/dhcp_option_tlv_parser_top_tb.sv =====
// Self-checking testbench for dhcp_option_tlv_parser_top: streams option areas
// byte by byte and compares every result item against a behavioral predictor.
// Depends on dotp_pkg, dotp_chan_if and the parser RTL.
module dhcp_option_tlv_parser_top_tb;
    import dotp_pkg::*;

    // Magic cookie, first byte in the top octet.
    localparam logic [31:0] MAGIC = 32'h6382_5363;
    localparam int COOKIE_LEN = 4;
    localparam int ITEM_TARGET = 650;
    localparam int TAIL_CYCLES = 20;
    localparam int TIMEOUT_UNITS = 2_000_000;

    // Tracks the parser state per accepted byte and holds the results it owes.
    class dhcp_result_tracker;
        t_phase            phase;
        logic [7:0]        idx;
        logic [7:0]        cur_code;
        logic [7:0]        remain;
        logic [31:0]       word;
        logic [31:0]       mask_word;
        logic [31:0]       gw_word;
        logic [31:0]       dns_word;
        logic [31:0]       lease_word;
        logic [31:0]       client_word;
        logic [FLAGS_W-1:0] seen;
        t_result           owed_results[$];
        int unsigned       errors;

        function new();
            phase = PH_COOKIE;
            idx = '0;
            cur_code = '0;
            remain = '0;
            word = '0;
            mask_word = '0;
            gw_word = '0;
            dns_word = '0;
            lease_word = '0;
            client_word = '0;
            seen = FLAG_NONE;
            errors = 0;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // Only these four options have their value captured.
        function logic [FLAGS_W-1:0] capture_flag(logic [7:0] code);
            case (code)
                OPT_MASK:   return FLAG_MASK;
                OPT_ROUTER: return FLAG_ROUTER;
                OPT_DNS:    return FLAG_DNS;
                OPT_LEASE:  return FLAG_LEASE;
                default:    return FLAG_NONE;
            endcase
        endfunction

        // Advances the parser state by one accepted byte.
        function void take_byte(t_in_item it);
            t_phase             was;
            logic [FLAGS_W-1:0] flag;
            logic [7:0]         want;
            bit                 fire;
            t_status            st;
            t_result            r;
            was = phase;
            fire = 1'b0;
            st = ST_OK;
            case (phase)
                PH_COOKIE: begin
                    // The first byte of a frame samples the address and clears captures.
                    if (idx == 0) begin
                        client_word = it.client_address;
                        mask_word = '0;
                        gw_word = '0;
                        dns_word = '0;
                        lease_word = '0;
                        seen = FLAG_NONE;
                    end
                    want = MAGIC[8 * (3 - int'(idx[1:0])) +: 8];
                    if (it.option_byte != want) begin
                        fire = 1'b1;
                        st = ST_BADCOOKIE;
                    end else begin
                        idx = idx + 8'd1;
                        if (idx >= COOKIE_LEN) begin
                            idx = '0;
                            phase = PH_CODE;
                        end
                    end
                end
                PH_CODE: begin
                    if (it.option_byte == OPT_END) begin
                        fire = 1'b1;
                        st = ST_OK;
                    end else if (it.option_byte != OPT_PAD) begin
                        cur_code = it.option_byte;
                        phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    remain = it.option_byte;
                    idx = '0;
                    word = '0;
                    phase = (it.option_byte != 0) ? PH_VALUE : PH_CODE;
                end
                PH_VALUE: begin
                    // Big-endian capture of the first four value bytes only.
                    flag = capture_flag(cur_code);
                    if (flag != FLAG_NONE && idx < VALUE_BYTES) begin
                        word = {word[23:0], it.option_byte};
                        idx = idx + 8'd1;
                        if (idx == VALUE_BYTES) begin
                            case (flag)
                                FLAG_MASK:   mask_word = word;
                                FLAG_ROUTER: gw_word = word;
                                FLAG_DNS:    dns_word = word;
                                default:     lease_word = word;
                            endcase
                            seen = seen | flag;
                        end
                    end
                    remain = remain - 8'd1;
                    if (remain == 0)
                        phase = PH_CODE;
                end
                default: begin
                end
            endcase

            // A frame that ends before any result reports truncation.
            if (it.frame_last && !fire && was != PH_DRAIN) begin
                fire = 1'b1;
                st = ST_TRUNC;
            end

            if (fire) begin
                r.parse_status = st;
                r.assigned_address = client_word;
                r.netmask = mask_word;
                r.gateway = gw_word;
                r.name_server = dns_word;
                r.lease_seconds = lease_word;
                r.found_mask = seen;
                owed_results.push_back(r);
                phase = PH_DRAIN;
            end

            if (it.frame_last) begin
                phase = PH_COOKIE;
                idx = '0;
                remain = '0;
                word = '0;
                cur_code = '0;
            end
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %h got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compares an accepted result with the oldest owed one.
        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: result expected none got %h", $time, got);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            cmp("parse_status", 32'(want.parse_status), 32'(got.parse_status));
            cmp("assigned_address", want.assigned_address, got.assigned_address);
            cmp("netmask", want.netmask, got.netmask);
            cmp("gateway", want.gateway, got.gateway);
            cmp("name_server", want.name_server, got.name_server);
            cmp("lease_seconds", want.lease_seconds, got.lease_seconds);
            cmp("found_mask", 32'(want.found_mask), 32'(got.found_mask));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dotp_chan_if #(.t_payload(t_in_item)) in_ch ();
    dotp_chan_if #(.t_payload(t_result))  res_ch ();

    dhcp_option_tlv_parser_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (res_ch)
    );

    dhcp_result_tracker sb;
    logic [7:0]  frame_bytes[$];
    int unsigned sender_gap = 0;
    int unsigned recv_hold = 0;
    int unsigned bytes_sent = 0;
    bit          calm = 1'b0;

    always #1 i_clk = ~i_clk;

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Result side: random stalls after each item, and the check itself.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_hold = 0;
        end else if (res_ch.valid && res_ch.ready) begin
            sb.check_result(res_ch.payload);
            recv_hold = draw_wait();
            res_ch.ready <= (recv_hold == 0);
        end else if (recv_hold != 0) begin
            recv_hold = recv_hold - 1;
            res_ch.ready <= (recv_hold == 0);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Offers one byte and waits for it to be taken. Valid drops afterwards
    // only if a gap follows or the caller asks for it.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [31:0] addr, input bit drop_after);
        t_in_item it;
        repeat (sender_gap) @(posedge i_clk);
        it.option_byte = b;
        it.frame_last = last;
        it.client_address = addr;
        in_ch.payload <= it;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.take_byte(it);
        bytes_sent++;
        sender_gap = draw_wait();
        if (drop_after || sender_gap != 0)
            in_ch.valid <= 1'b0;
    endtask

    // Sends the built frame; only its first byte carries a meaningful address.
    task automatic send_frame(input logic [31:0] first_addr, input bit pause_after);
        int unsigned k;
        for (k = 0; k < frame_bytes.size(); k++)
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1,
                      (k == 0) ? first_addr : $urandom,
                      pause_after && k == frame_bytes.size() - 1);
        if (pause_after)
            do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic push_cookie();
        for (int i = 0; i < COOKIE_LEN; i++)
            frame_bytes.push_back(MAGIC[8 * (3 - i) +: 8]);
    endtask

    // Mostly well-formed option areas with random content; some noise,
    // corrupted cookies and frames cut short.
    task automatic build_random_frame();
        int unsigned kind, pick, len, r, cut, pos;
        logic [7:0]  code;
        bit          known;
        frame_bytes = {};
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        push_cookie();
        if (kind == 1) begin
            pos = $urandom_range(0, COOKIE_LEN - 1);
            frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        repeat ($urandom_range(0, 4)) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                frame_bytes.push_back(OPT_PAD);
            end else begin
                known = 1'b1;
                case (pick)
                    1, 5:    code = OPT_MASK;
                    2:       code = OPT_ROUTER;
                    3:       code = OPT_DNS;
                    4:       code = OPT_LEASE;
                    default: begin
                        code = 8'($urandom_range(1, 254));
                        known = 1'b0;
                    end
                endcase
                r = $urandom_range(0, 31);
                if (r == 0)
                    len = $urandom_range(0, 255);
                else if (r < 6)
                    len = $urandom_range(0, 3);
                else if (r < 10)
                    len = $urandom_range(5, 8);
                else
                    len = known ? 4 : $urandom_range(0, 6);
                frame_bytes.push_back(code);
                frame_bytes.push_back(8'(len));
                repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (kind == 2 || kind == 3) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end else begin
            frame_bytes.push_back(OPT_END);
            repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        bit          pause;
        int unsigned frame_no;
        sb = new();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pad, short router, mask with an extra value byte, then end.
        frame_bytes = {};
        push_cookie();
        frame_bytes.push_back(OPT_PAD);
        frame_bytes.push_back(OPT_ROUTER);
        frame_bytes.push_back(8'd2);
        frame_bytes.push_back(8'h11);
        frame_bytes.push_back(8'h22);
        frame_bytes.push_back(OPT_MASK);
        frame_bytes.push_back(8'd5);
        repeat (4) frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(OPT_END);
        send_frame(32'hFFFF_FFFF, 1'b1);

        // Bad cookie on the third byte, with a byte dropped after it.
        frame_bytes = {};
        frame_bytes.push_back(MAGIC[31:24]);
        frame_bytes.push_back(MAGIC[23:16]);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hAB);
        send_frame(32'h0000_0000, 1'b0);

        // Frame that ends inside the cookie.
        frame_bytes = {};
        frame_bytes.push_back(MAGIC[31:24]);
        send_frame(32'hA5A5_5A5A, 1'b0);

        // Zero-length option, then the frame ends without an end option.
        frame_bytes = {};
        push_cookie();
        frame_bytes.push_back(8'd7);
        frame_bytes.push_back(8'd0);
        send_frame(32'h1234_5678, 1'b0);

        // Random frames, with calm stretches and occasional full drains.
        frame_no = 0;
        while (bytes_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            build_random_frame();
            pause = (frame_no == 3) || ($urandom_range(0, 9) == 0) ||
                    (bytes_sent + frame_bytes.size() >= ITEM_TARGET);
            send_frame($urandom, pause);
            frame_no++;
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("dhcp_option_tlv_parser_top_tb: clean");
        else
            $display("dhcp_option_tlv_parser_top_tb: errors");
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #(TIMEOUT_UNITS);
        $display("dhcp_option_tlv_parser_top_tb: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/dotp_pkg.sv
design/dotp_chan_if.sv
design/dotp_parse_core.sv
design/dotp_out_reg.sv
design/dhcp_option_tlv_parser_top.sv
verif/dhcp_option_tlv_parser_top_tb.sv
